/* sv/tcpcs_pkg.sv */
// Package for the TCP-over-IPv4 checksum core.
// Holds header offsets, length limits and the ones'-complement add.
// No dependencies.
package tcpcs_pkg;

	localparam int unsigned PosW = 16;
	localparam int unsigned HdrW = 6;
	localparam int unsigned SumW = 16;

	localparam logic [PosW-1:0] PosMax     = 16'hFFFF;
	localparam logic [PosW-1:0] PosVerIhl  = 16'd0;
	localparam logic [PosW-1:0] PosLenHi   = 16'd2;
	localparam logic [PosW-1:0] PosLenLo   = 16'd3;
	localparam logic [PosW-1:0] PosProto   = 16'd9;
	localparam logic [PosW-1:0] PosAddrLo  = 16'd12;
	localparam logic [PosW-1:0] PosAddrHi  = 16'd19;
	localparam logic [PosW-1:0] PosSegMin  = 16'd4;
	localparam logic [PosW-1:0] OffCsumHi  = 16'd16;
	localparam logic [PosW-1:0] OffCsumLo  = 16'd17;
	localparam logic [HdrW-1:0] HdrMin     = 6'd20;

	function automatic logic [SumW-1:0] oc_add(input logic [SumW-1:0] a,
		input logic [SumW-1:0] b);
		logic [SumW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SumW-1:0] + {{(SumW-1){1'b0}}, s[SumW]};
	endfunction

endpackage

/* sv/tcp_checksum_over_ipv4_stream_core.sv */
// Top level of the TCP-over-IPv4 checksum core.
// Depends on tcpcs_pkg (constants, ones'-complement add).
// Single module: input register, per-byte update, result register.

// Takes an IPv4 packet one byte per word on the slave stream, tlast on the
// final byte, and returns one word per packet on the master stream: the TCP
// checksum (pseudo-header plus segment, checksum field counted as zero) in
// tdata and a length error flag in tuser, with tdata zero on error. Each
// byte passes one ones'-complement add, so a byte is taken every cycle
// but when the input stalls, which is only when a last byte meets a result
// not yet taken; the last byte passes the input, then the result register.
module tcp_checksum_over_ipv4_stream_core
	import tcpcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] tcp_checksum
	output logic        m_tuser    // [0] length_error
);

	logic            valid_s1;
	logic            last_s1;
	logic [7:0]      data_s1;
	logic            go_s1;

	logic [PosW-1:0] pos_q, pos_nxt;
	logic [HdrW-1:0] hdr_q, hdr_nxt;
	logic [PosW-1:0] total_q, total_nxt;
	logic [SumW-1:0] sum_q, sum_nxt;
	logic [7:0]      pend_q, pend_nxt;

	logic            out_valid_q;
	logic [SumW-1:0] csum_q;
	logic            err_q;

	logic [PosW-1:0] hdr_ext;
	logic [PosW-1:0] off;
	logic            in_seg;
	logic [7:0]      seg_byte;
	logic [7:0]      pair_byte;
	logic            do_pair;
	logic            do_proto;
	logic [SumW-1:0] addend;
	logic [SumW-1:0] sum_add;
	logic [PosW:0]   count;
	logic            err;
	logic [PosW-1:0] seg_len;
	logic [SumW-1:0] fin_a, fin_b;

	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_comb begin
		hdr_ext   = {{(PosW-HdrW){1'b0}}, hdr_q};
		off       = pos_q - hdr_ext;
		in_seg    = (pos_q >= hdr_ext) && (pos_q < total_q) && (pos_q >= PosSegMin);
		seg_byte  = (off == OffCsumHi || off == OffCsumLo) ? 8'h00 : data_s1;
		pair_byte = in_seg ? seg_byte : data_s1;
		do_pair   = in_seg || (pos_q >= PosAddrLo && pos_q <= PosAddrHi);
		do_proto  = !in_seg && (pos_q == PosProto);
		addend    = do_proto ? {8'h00, data_s1} : {pend_q, pair_byte};
		sum_add   = oc_add(sum_q, addend);

		hdr_nxt   = hdr_q;
		total_nxt = total_q;
		sum_nxt   = sum_q;
		pend_nxt  = pend_q;
		if (pos_q == PosVerIhl) begin
			hdr_nxt   = {data_s1[3:0], 2'b00};
			total_nxt = '0;
			sum_nxt   = '0;
			pend_nxt  = '0;
		end else if (pos_q == PosLenHi) begin
			total_nxt[15:8] = data_s1;
		end else if (pos_q == PosLenLo) begin
			total_nxt[7:0] = data_s1;
		end else if (do_proto) begin
			sum_nxt = sum_add;
		end else if (do_pair) begin
			if (!pos_q[0])
				pend_nxt = pair_byte;
			else
				sum_nxt = sum_add;
		end

		pos_nxt = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;

		count   = {1'b0, pos_q} + 1'b1;
		err     = (hdr_nxt < HdrMin) || (total_nxt < {{(PosW-HdrW){1'b0}}, hdr_nxt})
			|| (count < {1'b0, total_nxt});
		seg_len = total_nxt - {{(PosW-HdrW){1'b0}}, hdr_nxt};
		fin_a   = seg_len[0] ? oc_add(sum_nxt, {pend_nxt, 8'h00}) : sum_nxt;
		fin_b   = oc_add(fin_a, seg_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			total_q <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				hdr_q   <= '0;
				total_q <= '0;
				sum_q   <= '0;
				pend_q  <= '0;
			end else begin
				pos_q   <= pos_nxt;
				hdr_q   <= hdr_nxt;
				total_q <= total_nxt;
				sum_q   <= sum_nxt;
				pend_q  <= pend_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			csum_q <= err ? '0 : ~fin_b;
			err_q  <= err;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = csum_q;
	assign m_tuser  = err_q;

endmodule
